[hdl/pip_pkg.sv]
// shared types and constants for the polygon hit-test block
`default_nettype none
package pip_pkg;

	localparam int COORD_BITS   = 16;
	localparam int MAX_VERTICES = 64;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int ADDR_W       = $clog2(MAX_VERTICES);

	localparam logic [1:0] MODE_CLEAR  = 2'd0;
	localparam logic [1:0] MODE_APPEND = 2'd1;
	localparam logic [1:0] MODE_QUERY  = 2'd2;

	typedef struct packed {
		logic [1:0]                   mode;
		logic signed [COORD_BITS-1:0] x_coord;
		logic signed [COORD_BITS-1:0] y_coord;
	} req_item_t;

	typedef struct packed {
		logic                         inside_res;
		logic signed [COORD_BITS-1:0] box_min_x;
		logic signed [COORD_BITS-1:0] box_min_y;
		logic signed [COORD_BITS-1:0] box_max_x;
		logic signed [COORD_BITS-1:0] box_max_y;
		logic [CNT_W-1:0]             count_now;
		logic                         dropped;
	} rsp_item_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
	} vtx_t;

	typedef struct packed {
		logic start;
		logic issue;
		logic last;
	} edge_ctl_t;

endpackage
`default_nettype wire

[hdl/pip_edge_unit.sv]
// edge crossing pipeline: cross-multiplied side test and crossing parity
`default_nettype none
module pip_edge_unit
	import pip_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire edge_ctl_t ctl,
	input  wire vtx_t      rd_vtx,
	input  wire vtx_t      first_vtx,
	input  wire vtx_t      point,
	output logic           odd,
	output logic           busy
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;

	logic                 v_s1, last_s1;
	vtx_t                 prev_q;
	vtx_t                 endp;
	logic                 strad;
	logic signed [DW-1:0] dy, dpx, dex, dpy;
	logic signed [PW-1:0] lhs, rhs;
	logic                 dpos;

	logic                 v_s2, strad_s2, dpos_s2;
	logic signed [PW-1:0] lhs_s2, rhs_s2;
	logic                 hit;
	logic                 odd_q;

	always_comb begin
		endp  = last_s1 ? first_vtx : rd_vtx;
		strad = ($signed(prev_q.y) > $signed(point.y)) != ($signed(endp.y) > $signed(point.y));
		dy    = {endp.y[COORD_BITS-1], endp.y} - {prev_q.y[COORD_BITS-1], prev_q.y};
		dpx   = {point.x[COORD_BITS-1], point.x} - {prev_q.x[COORD_BITS-1], prev_q.x};
		dex   = {endp.x[COORD_BITS-1], endp.x} - {prev_q.x[COORD_BITS-1], prev_q.x};
		dpy   = {point.y[COORD_BITS-1], point.y} - {prev_q.y[COORD_BITS-1], prev_q.y};
		lhs   = dpx * dy;
		rhs   = dex * dpy;
		dpos  = !dy[DW-1] && (dy != '0);
	end

	// sense of the comparison follows the sign of the edge's y span
	assign hit = dpos_s2 ? (lhs_s2 < rhs_s2) : (rhs_s2 < lhs_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			v_s2    <= 1'b0;
			odd_q   <= 1'b0;
		end else begin
			v_s1    <= ctl.issue;
			last_s1 <= ctl.issue && ctl.last;
			v_s2    <= v_s1;
			if (ctl.start) begin
				odd_q <= 1'b0;
			end else if (v_s2 && strad_s2 && hit) begin
				odd_q <= !odd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			prev_q <= first_vtx;
		end else if (v_s1) begin
			prev_q <= endp;
		end
		strad_s2 <= strad;
		dpos_s2  <= dpos;
		lhs_s2   <= lhs;
		rhs_s2   <= rhs;
	end

	assign odd  = odd_q;
	assign busy = v_s1 || v_s2;

endmodule
`default_nettype wire

[hdl/point_in_polygon_test.sv]
// polygon hit-test block: vertex store, bounding box and crossing-number query
// response: clear, append, unused modes and queries on fewer than two vertices
//   return their item in the accept cycle's output register; a query walks
//   the vertex memory one edge per cycle over n vertices (n is one less when
//   the list closes on its first vertex) and takes no new item until done
// throughput: one clear or append per cycle while the output is not stalled
// reset: count and bounding box clear to zero; the vertex memory is not cleared
`default_nettype none
module point_in_polygon_test
	import pip_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire req_item_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_item_t      rsp
);

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FIRST = 3'd1; // first vertex arriving
	localparam logic [2:0] ST_LAST  = 3'd2; // last vertex arriving, closure check
	localparam logic [2:0] ST_WALK  = 3'd3; // one edge endpoint read per cycle
	localparam logic [2:0] ST_DRAIN = 3'd4; // wait for the edge pipe to empty

	logic [2:0] state_q;

	// vertex store, one entry holds x and y
	vtx_t mem [MAX_VERTICES];
	vtx_t rd_data_q;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;

	logic [CNT_W-1:0] count_q, count_d;
	logic signed [COORD_BITS-1:0] lo_x_q, lo_y_q, hi_x_q, hi_y_q;
	logic signed [COORD_BITS-1:0] lo_x_d, lo_y_d, hi_x_d, hi_y_d;
	logic                         drop_d;

	vtx_t             pt_q;
	vtx_t             v0_q;
	logic [CNT_W-1:0] n_eff_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] last_idx;

	logic      acc;
	logic      out_free;
	logic      is_query;
	logic      rsp_load;
	rsp_item_t rsp_d;
	rsp_item_t rsp_q;
	logic      rsp_valid_q;

	edge_ctl_t ctl;
	logic      odd;
	logic      edge_busy;
	logic      walk_last;

	// output register is free when empty or being drained this cycle
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != ST_IDLE) || !out_free;
	assign acc       = req_valid && !req_stall;
	assign is_query  = (req.mode == MODE_QUERY) && (count_q >= CNT_W'(2));
	assign last_idx  = count_q - CNT_W'(1);
	assign walk_last = (idx_q == n_eff_q);

	// next count, box and drop flag for a non-query item
	always_comb begin
		count_d = count_q;
		lo_x_d  = lo_x_q;
		lo_y_d  = lo_y_q;
		hi_x_d  = hi_x_q;
		hi_y_d  = hi_y_q;
		drop_d  = 1'b0;
		wr_en   = 1'b0;
		case (req.mode)
			MODE_CLEAR: begin
				count_d = '0;
				lo_x_d  = '0;
				lo_y_d  = '0;
				hi_x_d  = '0;
				hi_y_d  = '0;
			end
			MODE_APPEND: begin
				if (count_q >= CNT_W'(MAX_VERTICES)) begin
					drop_d = 1'b1;
				end else begin
					wr_en   = acc;
					count_d = count_q + CNT_W'(1);
					if (count_q == '0) begin
						lo_x_d = req.x_coord;
						hi_x_d = req.x_coord;
						lo_y_d = req.y_coord;
						hi_y_d = req.y_coord;
					end else begin
						if ($signed(req.x_coord) < $signed(lo_x_q)) lo_x_d = req.x_coord;
						if ($signed(req.x_coord) > $signed(hi_x_q)) hi_x_d = req.x_coord;
						if ($signed(req.y_coord) < $signed(lo_y_q)) lo_y_d = req.y_coord;
						if ($signed(req.y_coord) > $signed(hi_y_q)) hi_y_d = req.y_coord;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// result register input: queries take the walk's parity, others their update
	always_comb begin
		rsp_load = 1'b0;
		rsp_d.inside_res = 1'b0;
		rsp_d.box_min_x  = lo_x_d;
		rsp_d.box_min_y  = lo_y_d;
		rsp_d.box_max_x  = hi_x_d;
		rsp_d.box_max_y  = hi_y_d;
		rsp_d.count_now  = count_d;
		rsp_d.dropped    = drop_d;
		if (state_q == ST_DRAIN) begin
			// the waiting input item must not leak into a query's result
			rsp_load = !edge_busy && out_free;
			rsp_d.inside_res = odd;
			rsp_d.box_min_x  = lo_x_q;
			rsp_d.box_min_y  = lo_y_q;
			rsp_d.box_max_x  = hi_x_q;
			rsp_d.box_max_y  = hi_y_q;
			rsp_d.count_now  = count_q;
			rsp_d.dropped    = 1'b0;
		end else if (acc && !is_query) begin
			rsp_load = 1'b1;
		end
	end

	// read address per state; the read runs every cycle
	always_comb begin
		case (state_q)
			ST_FIRST: rd_addr = last_idx[ADDR_W-1:0];
			ST_WALK:  rd_addr = idx_q[ADDR_W-1:0];
			default:  rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[ADDR_W-1:0]] <= vtx_t'{x: req.x_coord, y: req.y_coord};
		end
		rd_data_q <= mem[rd_addr];
	end

	// edge pipe control
	always_comb begin
		ctl.start = (state_q == ST_LAST);
		ctl.issue = (state_q == ST_WALK);
		ctl.last  = walk_last;
	end

	pip_edge_unit u_edge (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.rd_vtx    (rd_data_q),
		.first_vtx (v0_q),
		.point     (pt_q),
		.odd       (odd),
		.busy      (edge_busy)
	);

	// sequencer, count and box
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			lo_x_q      <= '0;
			lo_y_q      <= '0;
			hi_x_q      <= '0;
			hi_y_q      <= '0;
			rsp_valid_q <= 1'b0;
			idx_q       <= '0;
			n_eff_q     <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						count_q <= count_d;
						lo_x_q  <= lo_x_d;
						lo_y_q  <= lo_y_d;
						hi_x_q  <= hi_x_d;
						hi_y_q  <= hi_y_d;
						if (is_query) begin
							state_q <= ST_FIRST;
						end
					end
				end
				ST_FIRST: begin
					state_q <= ST_LAST;
				end
				ST_LAST: begin
					// a closing vertex equal to the first one is left out of the walk
					if (rd_data_q == v0_q) begin
						n_eff_q <= last_idx;
					end else begin
						n_eff_q <= count_q;
					end
					idx_q   <= CNT_W'(1);
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (walk_last) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				ST_DRAIN: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (acc) begin
			pt_q <= vtx_t'{x: req.x_coord, y: req.y_coord};
		end
		if (state_q == ST_FIRST) begin
			v0_q <= rd_data_q;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// stored count never passes the store's depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_VERTICES))
		else $error("vertex count beyond capacity");

	// a refused append only happens with a full store
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.dropped |-> rsp.count_now == CNT_W'(MAX_VERTICES))
		else $error("drop flagged with room left");

	// an inside answer needs at least two stored vertices
	a_inside_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.inside_res |-> rsp.count_now >= CNT_W'(2))
		else $error("inside reported for a degenerate polygon");

	// the walk index stays within the effective edge count
	a_walk_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> (idx_q != '0) && (idx_q <= n_eff_q))
		else $error("walk index out of range");

endmodule
`default_nettype wire
